@@ rtl/tcrw_pkg.sv @@
`default_nettype none
package tcrw_pkg;

    localparam int MAX_CITIES_DEF     = 64;
    localparam int MAX_POPULATION_DEF = 32;
    localparam int DISTANCE_BITS_DEF  = 16;

    localparam int MODE_W       = 2;
    localparam int CITY_IDX_W   = 6;
    localparam int DIST_IN_W    = 16;
    localparam int SLOT_IN_W    = 5;
    localparam int POS_W        = 6;
    localparam int CITY_W       = 6;

    localparam int WSLOT_OUT_W  = 5;
    localparam int COST_OUT_W   = 22;
    localparam int POP_OUT_W    = 27;

    localparam int S_DATA_W     = 48;
    localparam int M_DATA_W     = 80;

    localparam int CFG_INDEX_W  = 8;
    localparam int CFG_DATA_W   = 8;
    localparam int CITY_COUNT_W = 7;
    localparam int POP_COUNT_W  = 6;

    localparam logic [CITY_COUNT_W-1:0] CITY_COUNT_RST = 7'd64;
    localparam logic [POP_COUNT_W-1:0]  POP_COUNT_RST  = 6'd32;

    localparam logic [CFG_INDEX_W-1:0] CFG_CITY_COUNT       = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_POPULATION_COUNT = 8'd1;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD_DIST = 2'd0,
        MODE_LOAD_TOUR = 2'd1,
        MODE_CANDIDATE = 2'd2,
        MODE_QUERY     = 2'd3
    } mode_t;

endpackage
`default_nettype wire

@@ rtl/tcrw_ram.sv @@
`default_nettype none
module tcrw_ram #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 16
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ rtl/tcrw_walker.sv @@
`default_nettype none
module tcrw_walker #(
    parameter int MAX_CITIES     = tcrw_pkg::MAX_CITIES_DEF,
    parameter int MAX_POPULATION = tcrw_pkg::MAX_POPULATION_DEF,
    parameter int DISTANCE_BITS  = tcrw_pkg::DISTANCE_BITS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  start,
    input  wire logic [$clog2(MAX_POPULATION+1)-1:0]   slot,
    input  wire logic [$clog2(MAX_CITIES+1)-1:0]       n,
    output logic [$clog2(MAX_POPULATION+1)+$clog2(MAX_CITIES)-1:0] tour_raddr,
    input  wire logic [tcrw_pkg::CITY_W-1:0]           tour_rdata,
    output logic [2*$clog2(MAX_CITIES)-1:0]            dist_raddr,
    input  wire logic [DISTANCE_BITS-1:0]              dist_rdata,
    output logic                                       done,
    output logic [DISTANCE_BITS+$clog2(MAX_CITIES)-1:0] cost
);

    localparam int CIDX_W = $clog2(MAX_CITIES);
    localparam int SLOT_W = $clog2(MAX_POPULATION+1);
    localparam int CNT_W  = $clog2(MAX_CITIES+1);
    localparam int COST_W = DISTANCE_BITS + CIDX_W;

    logic                          active_reg;
    logic [CNT_W-1:0]              step_reg;
    logic [SLOT_W-1:0]             slot_reg;
    logic                          b_valid_reg;
    logic                          b_first_reg;
    logic                          b_close_reg;
    logic [tcrw_pkg::CITY_W-1:0]   first_city_reg;
    logic [tcrw_pkg::CITY_W-1:0]   prev_city_reg;
    logic                          c_valid_reg;
    logic                          c_close_reg;
    logic                          c_leg_reg;
    logic [COST_W-1:0]             acc_reg;
    logic                          done_reg;
    logic [COST_W-1:0]             cost_reg;

    logic [tcrw_pkg::CITY_W-1:0]   cur_city;
    logic                          leg_ok;
    logic [COST_W-1:0]             sum_c;

    assign tour_raddr = {slot_reg, CIDX_W'(step_reg)};
    assign cur_city   = b_close_reg ? first_city_reg : tour_rdata;
    assign dist_raddr = {CIDX_W'(prev_city_reg), CIDX_W'(cur_city)};
    assign leg_ok     = (32'(prev_city_reg) < MAX_CITIES) && (32'(cur_city) < MAX_CITIES);
    assign sum_c      = acc_reg + (c_leg_reg ? COST_W'(dist_rdata) : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            done_reg    <= c_valid_reg && c_close_reg;
            b_valid_reg <= active_reg;
            c_valid_reg <= b_valid_reg;
            if (start) begin
                active_reg <= 1'b1;
            end else if (active_reg && (step_reg == n)) begin
                active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            step_reg <= '0;
            slot_reg <= slot;
        end else if (active_reg) begin
            step_reg <= step_reg + 1'b1;
        end
        b_first_reg <= (step_reg == '0);
        b_close_reg <= (step_reg == n);
        if (b_valid_reg) begin
            if (b_first_reg) begin
                first_city_reg <= tour_rdata;
            end
            if (!b_close_reg) begin
                prev_city_reg <= tour_rdata;
            end
        end
        c_close_reg <= b_close_reg;
        c_leg_reg   <= b_valid_reg && !b_first_reg && leg_ok;
        if (start) begin
            acc_reg <= '0;
        end else if (c_valid_reg) begin
            if (c_close_reg) begin
                acc_reg  <= '0;
                cost_reg <= sum_c;
            end else begin
                acc_reg <= sum_c;
            end
        end
    end

    assign done = done_reg;
    assign cost = cost_reg;

endmodule
`default_nettype wire

@@ rtl/tour_cost_replace_worst_top.sv @@
`default_nettype none
// Replace-worst step for a steady-state tour search. Distance, population and
// candidate loads are taken one word per cycle while the block is idle and the
// output can take a result, each answered by a result word carrying only
// result_kind. A final candidate city (mode 2 with tlast) walks every tour in use
// and then the candidate; each walk covers n legs, with n the clamped city count,
// fed through the single read port of the tour memory to the distance memory one
// leg per cycle. A replacement then copies the candidate into the worst slot. A
// cost query walks the tours in use the same way. No item is accepted during a
// walk or copy; configuration writes are taken at any time but only belong in idle
// periods. Memory contents are undefined until loaded.
module tour_cost_replace_worst_top #(
    parameter int MAX_CITIES     = tcrw_pkg::MAX_CITIES_DEF,
    parameter int MAX_POPULATION = tcrw_pkg::MAX_POPULATION_DEF,
    parameter int DISTANCE_BITS  = tcrw_pkg::DISTANCE_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // from_city, to_city, distance, slot, position, city, zero pad
    input  wire logic [tcrw_pkg::S_DATA_W-1:0]      s_tdata,
    // mode
    input  wire logic [tcrw_pkg::MODE_W-1:0]        s_tuser,
    input  wire logic                               s_tlast,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // replaced, worst_slot, candidate_cost, worst_cost, population_cost, zero pad
    output logic [tcrw_pkg::M_DATA_W-1:0]           m_tdata,
    // result_kind
    output logic [tcrw_pkg::MODE_W-1:0]             m_tuser,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tcrw_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [tcrw_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CIDX_W  = $clog2(MAX_CITIES);
    localparam int SLOT_W  = $clog2(MAX_POPULATION+1);
    localparam int CNT_W   = $clog2(MAX_CITIES+1);
    localparam int COST_W  = DISTANCE_BITS + CIDX_W;
    localparam int POP_W   = COST_W + SLOT_W;
    localparam int TA_W    = SLOT_W + CIDX_W;
    localparam int DA_W    = 2 * CIDX_W;
    localparam int T_DEPTH = (MAX_POPULATION + 1) * (2 ** CIDX_W);
    localparam int D_DEPTH = 2 ** DA_W;
    localparam logic [SLOT_W-1:0] CAND_SLOT = SLOT_W'(MAX_POPULATION);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_WAIT,
        S_COPY,
        S_DONE
    } state_t;

    state_t                                  state_reg;
    logic [tcrw_pkg::CITY_COUNT_W-1:0]       city_count_reg;
    logic [tcrw_pkg::POP_COUNT_W-1:0]        population_count_reg;
    logic                                    query_reg;
    logic                                    cand_phase_reg;
    logic [SLOT_W-1:0]                       idx_reg;
    logic [COST_W-1:0]                       worst_reg;
    logic [SLOT_W-1:0]                       worst_slot_reg;
    logic [COST_W-1:0]                       cand_cost_reg;
    logic                                    replaced_reg;
    logic [POP_W-1:0]                        sum_reg;
    logic [CNT_W-1:0]                        copy_step_reg;
    logic                                    copy_wr_reg;
    logic [CIDX_W-1:0]                       copy_pos_reg;
    logic                                    m_tvalid_reg;
    logic [tcrw_pkg::M_DATA_W-1:0]           m_tdata_reg;
    logic [tcrw_pkg::MODE_W-1:0]             m_tuser_reg;

    logic [tcrw_pkg::CITY_IDX_W-1:0]         in_from;
    logic [tcrw_pkg::CITY_IDX_W-1:0]         in_to;
    logic [tcrw_pkg::DIST_IN_W-1:0]          in_dist;
    logic [tcrw_pkg::SLOT_IN_W-1:0]          in_slot;
    logic [tcrw_pkg::POS_W-1:0]              in_pos;
    logic [tcrw_pkg::CITY_W-1:0]             in_city;
    tcrw_pkg::mode_t                         in_mode;
    logic                                    accept;
    logic                                    out_free;
    logic                                    walk_item;
    logic                                    out_load;

    logic [CNT_W-1:0]                        n_cl;
    logic [SLOT_W-1:0]                       p_cl;
    logic [SLOT_W-1:0]                       p_last;

    logic                                    dist_we;
    logic [DA_W-1:0]                         dist_waddr;
    logic [DA_W-1:0]                         dist_raddr;
    logic [DISTANCE_BITS-1:0]                dist_rdata;

    logic                                    in_tour_we;
    logic [TA_W-1:0]                         in_tour_waddr;
    logic                                    tour_we;
    logic [TA_W-1:0]                         tour_waddr;
    logic [tcrw_pkg::CITY_W-1:0]             tour_wdata;
    logic [TA_W-1:0]                         tour_raddr;
    logic [TA_W-1:0]                         walk_raddr;
    logic [tcrw_pkg::CITY_W-1:0]             tour_rdata;

    logic                                    walk_start;
    logic [SLOT_W-1:0]                       walk_slot;
    logic                                    walk_done;
    logic [COST_W-1:0]                       walk_cost;
    logic [tcrw_pkg::M_DATA_W-1:0]           result_word;

    assign in_from = s_tdata[5:0];
    assign in_to   = s_tdata[11:6];
    assign in_dist = s_tdata[27:12];
    assign in_slot = s_tdata[32:28];
    assign in_pos  = s_tdata[38:33];
    assign in_city = s_tdata[44:39];
    assign in_mode = tcrw_pkg::mode_t'(s_tuser);

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign walk_item = (in_mode == tcrw_pkg::MODE_QUERY)
                       || ((in_mode == tcrw_pkg::MODE_CANDIDATE) && s_tlast);
    assign out_load  = ((state_reg == S_IDLE) && accept && !walk_item)
                       || ((state_reg == S_DONE) && out_free);

    always_comb begin
        if (city_count_reg == '0) begin
            n_cl = CNT_W'(1);
        end else if (32'(city_count_reg) > MAX_CITIES) begin
            n_cl = CNT_W'(MAX_CITIES);
        end else begin
            n_cl = CNT_W'(city_count_reg);
        end
        if (population_count_reg == '0) begin
            p_cl = SLOT_W'(1);
        end else if (32'(population_count_reg) > MAX_POPULATION) begin
            p_cl = SLOT_W'(MAX_POPULATION);
        end else begin
            p_cl = SLOT_W'(population_count_reg);
        end
    end
    assign p_last = p_cl - 1'b1;

    assign dist_we    = accept && (in_mode == tcrw_pkg::MODE_LOAD_DIST)
                        && (32'(in_from) < MAX_CITIES) && (32'(in_to) < MAX_CITIES);
    assign dist_waddr = {CIDX_W'(in_from), CIDX_W'(in_to)};

    always_comb begin
        in_tour_we    = 1'b0;
        in_tour_waddr = {CAND_SLOT, CIDX_W'(in_pos)};
        if (accept && (in_mode == tcrw_pkg::MODE_LOAD_TOUR)) begin
            in_tour_we    = (32'(in_slot) < MAX_POPULATION) && (32'(in_pos) < MAX_CITIES);
            in_tour_waddr = {SLOT_W'(in_slot), CIDX_W'(in_pos)};
        end else if (accept && (in_mode == tcrw_pkg::MODE_CANDIDATE)) begin
            in_tour_we    = (32'(in_pos) < MAX_CITIES);
        end
    end

    assign tour_we    = copy_wr_reg || in_tour_we;
    assign tour_waddr = copy_wr_reg ? {worst_slot_reg, copy_pos_reg} : in_tour_waddr;
    assign tour_wdata = copy_wr_reg ? tour_rdata : in_city;
    assign tour_raddr = (state_reg == S_COPY) ? {CAND_SLOT, CIDX_W'(copy_step_reg)}
                                              : walk_raddr;

    assign walk_start = (state_reg == S_START);
    assign walk_slot  = cand_phase_reg ? CAND_SLOT : idx_reg;

    assign result_word = {
        {(tcrw_pkg::M_DATA_W - 1 - tcrw_pkg::WSLOT_OUT_W - 2 * tcrw_pkg::COST_OUT_W
          - tcrw_pkg::POP_OUT_W){1'b0}},
        tcrw_pkg::POP_OUT_W'(sum_reg),
        tcrw_pkg::COST_OUT_W'(worst_reg),
        tcrw_pkg::COST_OUT_W'(cand_cost_reg),
        tcrw_pkg::WSLOT_OUT_W'(worst_slot_reg),
        replaced_reg
    };

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            city_count_reg       <= tcrw_pkg::CITY_COUNT_RST;
            population_count_reg <= tcrw_pkg::POP_COUNT_RST;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == tcrw_pkg::CFG_CITY_COUNT) begin
                city_count_reg <= tcrw_pkg::CITY_COUNT_W'(cfg_data);
            end else if (cfg_index == tcrw_pkg::CFG_POPULATION_COUNT) begin
                population_count_reg <= tcrw_pkg::POP_COUNT_W'(cfg_data);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            query_reg      <= 1'b0;
            cand_phase_reg <= 1'b0;
            idx_reg        <= '0;
            worst_reg      <= '0;
            worst_slot_reg <= '0;
            cand_cost_reg  <= '0;
            replaced_reg   <= 1'b0;
            sum_reg        <= '0;
            copy_step_reg  <= '0;
            copy_wr_reg    <= 1'b0;
            copy_pos_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            m_tuser_reg    <= '0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            copy_wr_reg <= (state_reg == S_COPY) && (32'(copy_step_reg) < MAX_CITIES);
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        query_reg      <= (in_mode == tcrw_pkg::MODE_QUERY);
                        cand_phase_reg <= 1'b0;
                        idx_reg        <= '0;
                        worst_reg      <= '0;
                        worst_slot_reg <= '0;
                        cand_cost_reg  <= '0;
                        replaced_reg   <= 1'b0;
                        sum_reg        <= '0;
                        if (walk_item) begin
                            state_reg <= S_START;
                        end else begin
                            m_tdata_reg  <= '0;
                            m_tuser_reg  <= in_mode;
                        end
                    end
                end
                S_START: begin
                    state_reg <= S_WAIT;
                end
                S_WAIT: begin
                    if (walk_done) begin
                        if (query_reg) begin
                            sum_reg <= sum_reg + POP_W'(walk_cost);
                            if (idx_reg == p_last) begin
                                state_reg <= S_DONE;
                            end else begin
                                idx_reg   <= idx_reg + 1'b1;
                                state_reg <= S_START;
                            end
                        end else if (!cand_phase_reg) begin
                            if ((idx_reg == '0) || (walk_cost > worst_reg)) begin
                                worst_reg      <= walk_cost;
                                worst_slot_reg <= idx_reg;
                            end
                            if (idx_reg == p_last) begin
                                cand_phase_reg <= 1'b1;
                            end else begin
                                idx_reg <= idx_reg + 1'b1;
                            end
                            state_reg <= S_START;
                        end else begin
                            cand_cost_reg <= walk_cost;
                            if (walk_cost < worst_reg) begin
                                replaced_reg  <= 1'b1;
                                copy_step_reg <= '0;
                                state_reg     <= S_COPY;
                            end else begin
                                state_reg <= S_DONE;
                            end
                        end
                    end
                end
                S_COPY: begin
                    if (32'(copy_step_reg) < MAX_CITIES) begin
                        copy_pos_reg  <= CIDX_W'(copy_step_reg);
                        copy_step_reg <= copy_step_reg + 1'b1;
                    end else begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        m_tdata_reg  <= result_word;
                        m_tuser_reg  <= query_reg ? tcrw_pkg::MODE_QUERY
                                                  : tcrw_pkg::MODE_CANDIDATE;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    tcrw_ram #(
        .DEPTH  (D_DEPTH),
        .ADDR_W (DA_W),
        .DATA_W (DISTANCE_BITS)
    ) u_dist_mem (
        .aclk  (aclk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (DISTANCE_BITS'(in_dist)),
        .raddr (dist_raddr),
        .rdata (dist_rdata)
    );

    tcrw_ram #(
        .DEPTH  (T_DEPTH),
        .ADDR_W (TA_W),
        .DATA_W (tcrw_pkg::CITY_W)
    ) u_tour_mem (
        .aclk  (aclk),
        .we    (tour_we),
        .waddr (tour_waddr),
        .wdata (tour_wdata),
        .raddr (tour_raddr),
        .rdata (tour_rdata)
    );

    tcrw_walker #(
        .MAX_CITIES     (MAX_CITIES),
        .MAX_POPULATION (MAX_POPULATION),
        .DISTANCE_BITS  (DISTANCE_BITS)
    ) u_walker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (walk_start),
        .slot       (walk_slot),
        .n          (n_cl),
        .tour_raddr (walk_raddr),
        .tour_rdata (tour_rdata),
        .dist_raddr (dist_raddr),
        .dist_rdata (dist_rdata),
        .done       (walk_done),
        .cost       (walk_cost)
    );

endmodule
`default_nettype wire
